### hw/rtl/mrup_pkg.sv
// Shared constants, command and status types for the parenthesis removal unit.
package mrup_pkg;

   localparam int MAX_LEN = 64;
   localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CNT_W   = $clog2(MAX_LEN + 1);
   localparam int CHAR_W  = 8;

   localparam logic [CHAR_W-1:0] OPEN_BR  = 8'h28;
   localparam logic [CHAR_W-1:0] CLOSE_BR = 8'h29;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // One classified request, handed from the front to the back.
   typedef struct packed {
      logic              store;
      logic [ADDR_W-1:0] pos;
      logic [CHAR_W-1:0] char_val;
      logic              keep;
      logic              push;
      logic [ADDR_W-1:0] push_idx;
      logic              fin;
      logic              ovf;
      logic [CNT_W-1:0]  fill;
      logic [CNT_W-1:0]  depth;
   } cmd_type;

   typedef struct packed {
      logic not_empty;
      logic not_full;
   } q_status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SWEEP,
      BK_DRAIN
   } back_state_type;

endpackage

### hw/rtl/mrup_if.sv
// Valid/ready channel interfaces for requests and results.
interface mrup_req_if;
   import mrup_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_in;
   logic              end_of_string;

   modport source (output valid, output char_in, output end_of_string, input ready);
   modport sink   (input valid, input char_in, input end_of_string, output ready);
endinterface

interface mrup_rsp_if;
   import mrup_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_out;
   logic              last_out;
   logic              none_kept;
   logic              overflowed;

   modport source (output valid, output char_out, output last_out, output none_kept,
                   output overflowed, input ready);
   modport sink   (input valid, input char_out, input last_out, input none_kept,
                   input overflowed, output ready);
endinterface

### hw/rtl/min_remove_unbalanced_parens_unit.sv
// Top level of the minimum-removal parenthesis filter: front, queue and back.
// The unit takes a string one byte per request and returns the bytes that survive
// once every unmatched ')' and every unmatched '(' is struck, in their original
// order, with last_out on the final result. A string with nothing left gives one
// result with none_kept and last_out set. Up to MAX_LEN (64) bytes are buffered;
// later bytes of the same string are dropped and every result of that string
// reports overflowed. Timing: requests are taken one per cycle while the 4-entry
// command queue has room. After the end-of-string request leaves the queue, the
// back strikes the unmatched opens (one stack RAM read per open bracket still
// pending) and then walks the byte buffer one address per cycle while the result
// port is not holding a kept byte back, with results at up to one per cycle under
// no backpressure. Bytes of the next string enter the queue meanwhile and wait
// there; requests stall once it fills. No clearing pass is needed after reset:
// only entries written for the current string are ever read.
module min_remove_unbalanced_parens_unit (
   input  logic       clock,
   input  logic       reset,
   mrup_req_if.sink   req_chan,
   mrup_rsp_if.source rsp_chan
);
   import mrup_pkg::*;

   // Front-to-queue and queue-to-back command path.
   cmd_type      front_cmd;
   cmd_type      head_cmd;
   logic         cmd_push;
   logic         cmd_pop;
   q_status_type q_stat;

   // Classify each request: buffer position, keep bit, stack push, overflow.
   mrup_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_stat   (q_stat),
      .cmd_push (cmd_push),
      .cmd      (front_cmd)
   );

   // Hold classified requests so the front keeps loading while the back drains.
   mrup_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (cmd_push),
      .wr_cmd (front_cmd),
      .pop    (cmd_pop),
      .rd_cmd (head_cmd),
      .q_stat (q_stat)
   );

   // Write buffers, strike pending opens at the end, and drain kept bytes.
   mrup_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_stat   (q_stat),
      .cmd      (head_cmd),
      .pop      (cmd_pop),
      .rsp_chan (rsp_chan)
   );

`ifndef NO_ASSERTIONS
   // A none-kept result always closes its run.
   a_none_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.none_kept |-> rsp_chan.last_out)
      else $error("none_kept result without last_out");

   // A request is only taken while the queue has room.
   a_no_queue_overrun: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |-> q_stat.not_full)
      else $error("request accepted into a full queue");

   // The back never pops an empty queue.
   a_no_queue_underrun: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> q_stat.not_empty)
      else $error("command popped from an empty queue");

   // Results are idle right after reset.
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("result valid right after reset");
`endif
endmodule

### hw/rtl/mrup_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mrup_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### hw/rtl/mrup_front.sv
// Front end: accepts bytes, tracks fill and open-bracket depth, classifies each request.
module mrup_front (
   input  logic                   clock,
   input  logic                   reset,
   mrup_req_if.sink               req_chan,
   input  mrup_pkg::q_status_type q_stat,
   output logic                   cmd_push,
   output mrup_pkg::cmd_type      cmd
);
   import mrup_pkg::*;

   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] depth_ff, depth_in;
   logic             ovf_ff, ovf_in;
   logic             accept;
   logic             full;

   assign req_chan.ready = q_stat.not_full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign full           = (fill_ff == CNT_W'(MAX_LEN));
   assign cmd_push       = accept;

   always_comb begin
      fill_in  = fill_ff;
      depth_in = depth_ff;
      ovf_in   = ovf_ff;

      cmd          = '0;
      cmd.char_val = req_chan.char_in;
      cmd.pos      = fill_ff[ADDR_W-1:0];
      cmd.push_idx = depth_ff[ADDR_W-1:0];
      cmd.keep     = 1'b1;
      cmd.fin      = req_chan.end_of_string;

      if (accept) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            cmd.store = 1'b1;
            fill_in   = fill_ff + CNT_W'(1);
            if (req_chan.char_in == OPEN_BR) begin
               cmd.push = 1'b1;
               depth_in = depth_ff + CNT_W'(1);
            end else if (req_chan.char_in == CLOSE_BR) begin
               if (depth_ff != '0) begin
                  depth_in = depth_ff - CNT_W'(1);
               end else begin
                  cmd.keep = 1'b0;
               end
            end
         end
      end

      cmd.ovf   = ovf_in;
      cmd.fill  = fill_in;
      cmd.depth = depth_in;

      // End of string: start the next one from scratch.
      if (accept && req_chan.end_of_string) begin
         fill_in  = '0;
         depth_in = '0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         depth_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         depth_ff <= depth_in;
         ovf_ff   <= ovf_in;
      end
   end
endmodule

### hw/rtl/mrup_queue.sv
// Short command queue between the front and the back.
module mrup_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  mrup_pkg::cmd_type      wr_cmd,
   input  logic                   pop,
   output mrup_pkg::cmd_type      rd_cmd,
   output mrup_pkg::q_status_type q_stat
);
   import mrup_pkg::*;

   cmd_type              slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + Q_CNT_W'(1);
         2'b01:   count_in = count_ff - Q_CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   assign q_stat.not_empty = (count_ff != '0);
   assign q_stat.not_full  = (count_ff != Q_CNT_W'(Q_DEPTH));
   assign rd_cmd           = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule

### hw/rtl/mrup_back.sv
// Back end: writes buffers, strikes unmatched opens, drains kept bytes to the result port.
module mrup_back (
   input  logic                   clock,
   input  logic                   reset,
   input  mrup_pkg::q_status_type q_stat,
   input  mrup_pkg::cmd_type      cmd,
   output logic                   pop,
   mrup_rsp_if.source             rsp_chan
);
   import mrup_pkg::*;

   back_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  depth_ff, depth_in;
   logic              ovf_ff, ovf_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              rd_valid_ff, rd_valid_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [CHAR_W-1:0] pend_char_ff, pend_char_in;
   logic              out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0] out_char_ff, out_char_in;
   logic              out_last_ff, out_last_in;
   logic              out_none_ff, out_none_in;
   logic              out_ovf_ff, out_ovf_in;

   logic              char_wr_en, char_rd_en;
   logic [CHAR_W-1:0] char_rd_data;
   logic              keep_wr_en, keep_rd_en;
   logic [ADDR_W-1:0] keep_wr_addr;
   logic              keep_wr_data;
   logic              keep_rd_data;
   logic              stack_wr_en, stack_rd_en;
   logic [ADDR_W-1:0] stack_rd_data;

   logic              out_free;
   logic              issue;
   logic              consume;

   mrup_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_char_ram (
      .clock   (clock),
      .wr_en   (char_wr_en),
      .wr_addr (cmd.pos),
      .wr_data (cmd.char_val),
      .rd_en   (char_rd_en),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (char_rd_data)
   );

   mrup_ram #(.WIDTH(1), .DEPTH(MAX_LEN)) u_keep_ram (
      .clock   (clock),
      .wr_en   (keep_wr_en),
      .wr_addr (keep_wr_addr),
      .wr_data (keep_wr_data),
      .rd_en   (keep_rd_en),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (keep_rd_data)
   );

   mrup_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_LEN)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_wr_en),
      .wr_addr (cmd.push_idx),
      .wr_data (cmd.pos),
      .rd_en   (stack_rd_en),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (stack_rd_data)
   );

   assign out_free = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      depth_in      = depth_ff;
      ovf_in        = ovf_ff;
      idx_in        = idx_ff;
      rd_valid_in   = rd_valid_ff;
      pend_valid_in = pend_valid_ff;
      pend_char_in  = pend_char_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_char_in   = out_char_ff;
      out_last_in   = out_last_ff;
      out_none_in   = out_none_ff;
      out_ovf_in    = out_ovf_ff;

      pop          = 1'b0;
      char_wr_en   = 1'b0;
      char_rd_en   = 1'b0;
      keep_wr_en   = 1'b0;
      keep_rd_en   = 1'b0;
      keep_wr_addr = cmd.pos;
      keep_wr_data = cmd.keep;
      stack_wr_en  = 1'b0;
      stack_rd_en  = 1'b0;
      issue        = 1'b0;
      consume      = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            pop = q_stat.not_empty;
            if (pop) begin
               char_wr_en  = cmd.store;
               keep_wr_en  = cmd.store;
               stack_wr_en = cmd.store && cmd.push;
               if (cmd.fin) begin
                  fill_in  = cmd.fill;
                  depth_in = cmd.depth;
                  ovf_in   = cmd.ovf;
                  idx_in   = '0;
                  state_in = BK_SWEEP;
               end
            end
         end

         BK_SWEEP: begin
            issue       = (idx_ff != depth_ff);
            stack_rd_en = issue;
            rd_valid_in = issue;
            if (issue) begin
               idx_in = idx_ff + CNT_W'(1);
            end
            if (rd_valid_ff) begin
               keep_wr_en   = 1'b1;
               keep_wr_addr = stack_rd_data;
               keep_wr_data = 1'b0;
            end
            if (!issue && !rd_valid_ff) begin
               idx_in   = '0;
               state_in = BK_DRAIN;
            end
         end

         BK_DRAIN: begin
            consume = rd_valid_ff && !(keep_rd_data && pend_valid_ff && !out_free);
            issue   = (idx_ff != fill_ff) && (!rd_valid_ff || consume);
            char_rd_en = issue;
            keep_rd_en = issue;
            if (issue) begin
               idx_in      = idx_ff + CNT_W'(1);
               rd_valid_in = 1'b1;
            end else if (consume) begin
               rd_valid_in = 1'b0;
            end
            if (consume && keep_rd_data) begin
               if (pend_valid_ff) begin
                  out_valid_in = 1'b1;
                  out_char_in  = pend_char_ff;
                  out_last_in  = 1'b0;
                  out_none_in  = 1'b0;
                  out_ovf_in   = ovf_ff;
               end
               pend_valid_in = 1'b1;
               pend_char_in  = char_rd_data;
            end
            if ((idx_ff == fill_ff) && !rd_valid_ff && out_free) begin
               out_valid_in  = 1'b1;
               out_char_in   = pend_valid_ff ? pend_char_ff : '0;
               out_last_in   = 1'b1;
               out_none_in   = !pend_valid_ff;
               out_ovf_in    = ovf_ff;
               pend_valid_in = 1'b0;
               state_in      = BK_IDLE;
            end
         end

         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         fill_ff       <= '0;
         depth_ff      <= '0;
         ovf_ff        <= 1'b0;
         idx_ff        <= '0;
         rd_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         depth_ff      <= depth_in;
         ovf_ff        <= ovf_in;
         idx_ff        <= idx_in;
         rd_valid_ff   <= rd_valid_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_char_ff <= pend_char_in;
      out_char_ff  <= out_char_in;
      out_last_ff  <= out_last_in;
      out_none_ff  <= out_none_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.char_out   = out_char_ff;
   assign rsp_chan.last_out   = out_last_ff;
   assign rsp_chan.none_kept  = out_none_ff;
   assign rsp_chan.overflowed = out_ovf_ff;
endmodule

### sim/tb_top.sv
// Testbench for the parenthesis removal unit: queued strings, scoreboard and watchdog.
module tb_top;
   import mrup_pkg::*;

   // Idle cycles allowed with no request or result moving before the run is abandoned.
   localparam int WATCHDOG_LIMIT = 3000;
   // Cycles to keep watching the result channel once nothing is expected any more.
   localparam int TAIL_CYCLES    = 200;
   localparam int TARGET_ITEMS   = 420;

   typedef struct {
      logic [CHAR_W-1:0] char_val;
      logic              fin;
      int                gap_after;
   } str_byte_type;

   typedef struct {
      logic [CHAR_W-1:0] char_out;
      logic              last_out;
      logic              none_kept;
      logic              overflowed;
   } kept_byte_type;

   logic clock;
   logic reset;

   mrup_req_if req_bus ();
   mrup_rsp_if rsp_bus ();

   min_remove_unbalanced_parens_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Stimulus waiting to be offered, and results the predictor says must come back.
   str_byte_type  pending_bytes[$];
   kept_byte_type expected_kept[$];

   // Predictor's own copy of the string being assembled.
   logic [CHAR_W-1:0] str_bytes [MAX_LEN];
   bit                str_keep  [MAX_LEN];
   logic [ADDR_W-1:0] open_pos  [MAX_LEN];
   int                open_depth;
   int                str_fill;
   bit                str_ovf;

   int  error_count;
   int  idle_cycles;
   bit  run_done;
   int  drv_gap_left;
   int  stall_left;
   int  calm_left;

   always #5 clock = ~clock;

   // Mostly back-to-back, sometimes a short pause, rarely a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 12)
         return 0;
      else if (r < 18)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 40);
   endfunction

   // Fold one accepted request into the string and, on the final byte,
   // queue every byte that survives bracket matching.
   task automatic absorb_request(input logic [CHAR_W-1:0] c, input logic fin);
      int            i;
      int            last_idx;
      kept_byte_type kb;
      // Drop bytes once the buffer is full; they take no part in matching.
      if (str_fill >= MAX_LEN) begin
         str_ovf = 1'b1;
      end else begin
         str_bytes[str_fill] = c;
         str_keep[str_fill]  = 1'b1;
         if (c == OPEN_BR) begin
            open_pos[open_depth] = str_fill[ADDR_W-1:0];
            open_depth++;
         end else if (c == CLOSE_BR) begin
            // Strike a close with no pending open.
            if (open_depth > 0)
               open_depth--;
            else
               str_keep[str_fill] = 1'b0;
         end
         str_fill++;
      end
      if (!fin)
         return;
      // Strike every open still waiting for its close.
      for (i = 0; i < open_depth; i++)
         str_keep[open_pos[i]] = 1'b0;
      last_idx = -1;
      for (i = 0; i < str_fill; i++)
         if (str_keep[i])
            last_idx = i;
      if (last_idx < 0) begin
         // Nothing survived: a single marker result.
         kb.char_out   = '0;
         kb.last_out   = 1'b1;
         kb.none_kept  = 1'b1;
         kb.overflowed = str_ovf;
         expected_kept = {expected_kept, kb};
      end else begin
         for (i = 0; i <= last_idx; i++) begin
            if (str_keep[i]) begin
               kb.char_out   = str_bytes[i];
               kb.last_out   = (i == last_idx);
               kb.none_kept  = 1'b0;
               kb.overflowed = str_ovf;
               expected_kept = {expected_kept, kb};
            end
         end
      end
      open_depth = 0;
      str_fill   = 0;
      str_ovf    = 1'b0;
   endtask

   task automatic queue_byte(input logic [CHAR_W-1:0] c, input logic fin, input int gap);
      str_byte_type sb;
      sb.char_val   = c;
      sb.fin        = fin;
      sb.gap_after  = gap;
      pending_bytes = {pending_bytes, sb};
   endtask

   // Brackets dominate so that matching gets deep; other bytes are random.
   task automatic queue_random_string(input int len, input bit calm);
      int                k;
      int                r;
      logic [CHAR_W-1:0] c;
      for (k = 0; k < len; k++) begin
         r = $urandom_range(0, 9);
         if (r < 4)
            c = OPEN_BR;
         else if (r < 8)
            c = CLOSE_BR;
         else
            c = $urandom_range(0, 255);
         queue_byte(c, (k == len - 1), calm ? 0 : pick_gap());
      end
   endtask

   // Driver: offer the next pending request whenever the channel is free,
   // and advance the predictor on every handshake.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         drv_gap_left = 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            absorb_request(req_bus.char_in, req_bus.end_of_string);
         if (!req_bus.valid || req_bus.ready) begin
            if (drv_gap_left > 0) begin
               // Hold off for the gap that follows the last request.
               req_bus.valid <= 1'b0;
               drv_gap_left--;
            end else if (pending_bytes.size() > 0) begin
               req_bus.valid         <= 1'b1;
               req_bus.char_in       <= pending_bytes[0].char_val;
               req_bus.end_of_string <= pending_bytes[0].fin;
               drv_gap_left = pending_bytes[0].gap_after;
               void'(pending_bytes.pop_front());
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall at random, with occasional calm stretches of full throughput.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
         calm_left  = 0;
      end else begin
         if (calm_left > 0)
            calm_left--;
         else if ($urandom_range(0, 49) == 0)
            calm_left = 100;
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else if (calm_left == 0 && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left = pick_gap();
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Monitor: compare every accepted result with the oldest expectation.
   always @(posedge clock) begin
      kept_byte_type kb;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_kept.size() == 0) begin
            $error("unexpected result: char_out %0h last_out %0b none_kept %0b overflowed %0b",
                   rsp_bus.char_out, rsp_bus.last_out, rsp_bus.none_kept, rsp_bus.overflowed);
            error_count++;
         end else begin
            kb = expected_kept.pop_front();
            // char_out carries no meaning on a none-kept marker.
            if (!kb.none_kept && rsp_bus.char_out !== kb.char_out) begin
               $error("char_out: expected %0h, got %0h", kb.char_out, rsp_bus.char_out);
               error_count++;
            end
            if (rsp_bus.last_out !== kb.last_out) begin
               $error("last_out: expected %0b, got %0b", kb.last_out, rsp_bus.last_out);
               error_count++;
            end
            if (rsp_bus.none_kept !== kb.none_kept) begin
               $error("none_kept: expected %0b, got %0b", kb.none_kept, rsp_bus.none_kept);
               error_count++;
            end
            if (rsp_bus.overflowed !== kb.overflowed) begin
               $error("overflowed: expected %0b, got %0b", kb.overflowed, rsp_bus.overflowed);
               error_count++;
            end
         end
      end
   end

   // Watchdog: abandon the run when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || run_done || (req_bus.valid && req_bus.ready)
          || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int items;
      int len;
      int sel;
      clock                 = 1'b0;
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.char_in       = '0;
      req_bus.end_of_string = 1'b0;
      rsp_bus.ready         = 1'b0;
      open_depth            = 0;
      str_fill              = 0;
      str_ovf               = 1'b0;
      error_count           = 0;
      idle_cycles           = 0;
      run_done              = 1'b0;

      // Directed strings.
      // A lone close and a lone open: nothing survives.
      queue_byte(CLOSE_BR, 1'b1, 0);
      queue_byte(OPEN_BR, 1'b1, 2);
      // A matched pair survives whole.
      queue_byte(OPEN_BR, 1'b0, 0);
      queue_byte(CLOSE_BR, 1'b1, 0);
      // Close before open: both struck.
      queue_byte(CLOSE_BR, 1'b0, 1);
      queue_byte(OPEN_BR, 1'b1, 0);
      // Byte extremes pass through around struck and matched brackets.
      queue_byte(8'h00, 1'b0, 0);
      queue_byte(8'hFF, 1'b0, 0);
      queue_byte(OPEN_BR, 1'b0, 0);
      queue_byte(CLOSE_BR, 1'b0, 3);
      queue_byte(CLOSE_BR, 1'b0, 0);
      queue_byte(OPEN_BR, 1'b0, 0);
      queue_byte(8'h41, 1'b1, 0);
      // Nested opens with one left pending.
      queue_byte(OPEN_BR, 1'b0, 0);
      queue_byte(OPEN_BR, 1'b0, 0);
      queue_byte(8'h78, 1'b0, 0);
      queue_byte(CLOSE_BR, 1'b1, 0);
      // A single ordinary byte.
      queue_byte(8'h5A, 1'b1, 0);

      // Random strings: first a full buffer and an overflow that drops the final two bytes.
      queue_random_string(MAX_LEN, 1'b0);
      queue_random_string(MAX_LEN + 2, 1'b1);
      items = 2 * MAX_LEN + 2;
      while (items < TARGET_ITEMS) begin
         sel = $urandom_range(0, 19);
         if (sel == 0)
            len = $urandom_range(MAX_LEN + 1, MAX_LEN + 8);
         else if (sel == 1)
            len = $urandom_range(17, MAX_LEN);
         else
            len = $urandom_range(1, 16);
         queue_random_string(len, ($urandom_range(0, 3) == 0));
         items += len;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Drain: every request taken, every result back, then watch a while longer.
      while (pending_bytes.size() > 0 || req_bus.valid)
         @(posedge clock);
      while (expected_kept.size() > 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      run_done = 1'b1;
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
